### sv/scg_pkg.sv
`timescale 1ns / 1ps

package scg_pkg;

  // register indexes on the configuration port
  localparam int unsigned CFG_ADDR_BITS = 3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_PHASE_STEP   = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_PHASE_OFFSET = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_AMPLITUDE    = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SAMPLE_COUNT = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_TIME_START   = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_TIME_STEP    = 3'd5;
  localparam logic [CFG_ADDR_BITS-1:0] REG_ROUND_MODE   = 3'd6;

  localparam int unsigned CFG_DATA_BITS = 32;

  // reset values of the registers
  localparam logic [31:0] RST_PHASE_STEP   = 32'd0;
  localparam logic [31:0] RST_PHASE_OFFSET = 32'd0;
  localparam logic [15:0] RST_AMPLITUDE    = 16'd256;
  localparam logic [15:0] RST_SAMPLE_COUNT = 16'd101;
  localparam logic [31:0] RST_TIME_START   = 32'd0;
  localparam logic [30:0] RST_TIME_STEP    = 31'd655;
  localparam logic        RST_ROUND_MODE   = 1'b0;

  // default parameter values
  localparam int unsigned PHASE_BITS_DEF    = 32;
  localparam int unsigned ROM_ADDR_BITS_DEF = 10;
  localparam int unsigned INDEX_BITS_DEF    = 16;

  localparam int unsigned QUEUE_DEPTH = 4;

  // fixed field widths
  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned OIDX_BITS   = 16;
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned ROM_BITS    = 16;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef struct packed {
    logic [31:0]        phase_step;
    logic [31:0]        phase_offset;
    logic signed [15:0] amplitude;
    logic [15:0]        sample_count;
    logic [31:0]        time_start;
    logic [30:0]        time_step;
    logic               round_mode;
  } cfg_t;

  // quarter-wave cosine entry k, Q1.15, from a 13 term integer series
  function automatic logic [ROM_BITS-1:0] rom_entry(input int unsigned k,
                                                    input int unsigned abits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    x    = (PI_Q30 * 64'(k)) >> (abits + 1);
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = $signed(term);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if ((n & 1) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    v = ($unsigned(sum) * 64'd32768 + (64'd1 << 29)) >> 30;
    if (v > 64'd32768) begin
      v = 64'd32768;
    end
    return v[ROM_BITS-1:0];
  endfunction

endpackage

### sv/scg_queue.sv
`timescale 1ns / 1ps

module scg_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = scg_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  assign full    = (count_r == CNT_BITS'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

### sv/scg_front.sv
`timescale 1ns / 1ps

module scg_front #(
  parameter int unsigned PHASE_BITS    = scg_pkg::PHASE_BITS_DEF,
  parameter int unsigned ROM_ADDR_BITS = scg_pkg::ROM_ADDR_BITS_DEF,
  parameter int unsigned INDEX_BITS    = scg_pkg::INDEX_BITS_DEF,
  parameter int unsigned QW            = 2 + ROM_ADDR_BITS + scg_pkg::TIME_BITS
                                         + scg_pkg::OIDX_BITS + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  scg_pkg::cfg_t cfg,
  input  logic          in_valid,
  input  logic          in_restart,
  output logic          in_ready,
  input  logic          q_full,
  output logic          q_push,
  output logic [QW-1:0] q_data
);

  localparam int unsigned TOP_BITS = 2 + ROM_ADDR_BITS;
  localparam logic [31:0] IDX_MAX  = 32'((64'd1 << INDEX_BITS) - 64'd1);

  logic [PHASE_BITS-1:0]         step_al, off_al;
  logic [PHASE_BITS-1:0]         ph_r, ph_nxt, cur_ph;
  logic [scg_pkg::TIME_BITS-1:0] t_r, t_nxt, cur_t;
  logic [INDEX_BITS-1:0]         idx_r, idx_nxt, cur_idx, last_idx;
  logic [31:0]                   cnt_m1;
  logic                          accept;

  // phase registers are 32 bit turns; line them up with the accumulator
  if (PHASE_BITS > 32) begin : g_al_wide
    assign step_al = {cfg.phase_step, {(PHASE_BITS - 32){1'b0}}};
    assign off_al  = {cfg.phase_offset, {(PHASE_BITS - 32){1'b0}}};
  end else if (PHASE_BITS == 32) begin : g_al_same
    assign step_al = cfg.phase_step;
    assign off_al  = cfg.phase_offset;
  end else begin : g_al_narrow
    assign step_al = cfg.phase_step[31 -: PHASE_BITS];
    assign off_al  = cfg.phase_offset[31 -: PHASE_BITS];
  end

  // zero count acts as one, large counts clip to the index range
  assign cnt_m1   = (cfg.sample_count == '0) ? 32'd0 : 32'(cfg.sample_count) - 32'd1;
  assign last_idx = (cnt_m1 > IDX_MAX) ? '1 : cnt_m1[INDEX_BITS-1:0];

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  assign cur_idx = in_restart ? '0 : idx_r;
  assign cur_ph  = in_restart ? off_al : ph_r;
  assign cur_t   = in_restart ? cfg.time_start : t_r;

  assign q_data = {cur_ph[PHASE_BITS-1 -: TOP_BITS], cur_t,
                   scg_pkg::OIDX_BITS'(cur_idx), (cur_idx == last_idx)};

  always_comb begin
    ph_nxt  = ph_r;
    t_nxt   = t_r;
    idx_nxt = idx_r;
    if (accept) begin
      // sweep end also catches a count lowered mid-sweep
      if (cur_idx >= last_idx) begin
        idx_nxt = '0;
        ph_nxt  = off_al;
        t_nxt   = cfg.time_start;
      end else begin
        idx_nxt = cur_idx + 1'b1;
        ph_nxt  = cur_ph + step_al;
        t_nxt   = cur_t + {1'b0, cfg.time_step};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= {PHASE_BITS{1'b0}};
      t_r   <= scg_pkg::RST_TIME_START;
      idx_r <= '0;
    end else begin
      ph_r  <= ph_nxt;
      t_r   <= t_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

### sv/scg_back.sv
`timescale 1ns / 1ps

module scg_back #(
  parameter int unsigned ROM_ADDR_BITS = scg_pkg::ROM_ADDR_BITS_DEF,
  parameter int unsigned QW            = 2 + ROM_ADDR_BITS + scg_pkg::TIME_BITS
                                         + scg_pkg::OIDX_BITS + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  scg_pkg::cfg_t cfg,
  input  logic          q_empty,
  input  logic [QW-1:0] q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [scg_pkg::SAMPLE_BITS-1:0] out_sample,
  output logic [scg_pkg::TIME_BITS-1:0]   out_time,
  output logic [scg_pkg::OIDX_BITS-1:0]   out_index,
  output logic                            out_last
);

  localparam int unsigned ROM_SIZE = 1 << ROM_ADDR_BITS;
  localparam int unsigned TB       = scg_pkg::TIME_BITS;
  localparam int unsigned OB       = scg_pkg::OIDX_BITS;
  localparam int unsigned SB       = scg_pkg::SAMPLE_BITS;
  localparam int unsigned RB       = scg_pkg::ROM_BITS;
  localparam logic [32:0] POS_MAX  = 33'd8388607;
  localparam logic [32:0] NEG_MAX  = 33'd8388608;

  logic [RB-1:0] rom_tbl [ROM_SIZE];

  for (genvar k = 0; k < ROM_SIZE; k++) begin : g_rom
    assign rom_tbl[k] = scg_pkg::rom_entry(k, ROM_ADDR_BITS);
  end

  logic                     adv;
  logic [1:0]               quad;
  logic [ROM_ADDR_BITS-1:0] addr, addr_neg, rom_idx;

  // stage 1: table read
  logic          v1_r, zero1_r, neg1_r, last1_r;
  logic [RB-1:0] rom_q_r;
  logic [TB-1:0] t1_r;
  logic [OB-1:0] idx1_r;

  // stage 2: product
  logic                 v2_r, last2_r;
  logic signed [RB:0]   cos_s;
  logic signed [32:0]   prod_nxt, prod_r;
  logic [TB-1:0]        t2_r;
  logic [OB-1:0]        idx2_r;

  // output stage
  logic          neg3;
  logic [32:0]   mag_abs, mag_sh, mag_rnd;
  logic [SB-1:0] sample_nxt;
  logic          out_valid_r;
  logic [SB-1:0] sample_r;
  logic [TB-1:0] time_r;
  logic [OB-1:0] index_r;
  logic          last_r;

  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && !q_empty;

  assign quad     = q_data[QW-1 -: 2];
  assign addr     = q_data[QW-3 -: ROM_ADDR_BITS];
  assign addr_neg = '0 - addr;
  // odd quadrants read the table mirrored
  assign rom_idx  = quad[0] ? addr_neg : addr;

  always_ff @(posedge clk) begin
    if (adv) begin
      rom_q_r <= rom_tbl[rom_idx];
      zero1_r <= quad[0] && (addr == '0);
      neg1_r  <= quad[1] ^ quad[0];
      t1_r    <= q_data[TB+OB:OB+1];
      idx1_r  <= q_data[OB:1];
      last1_r <= q_data[0];
    end
  end

  always_comb begin
    if (zero1_r) begin
      cos_s = '0;
    end else if (neg1_r) begin
      cos_s = -$signed({1'b0, rom_q_r});
    end else begin
      cos_s = $signed({1'b0, rom_q_r});
    end
    prod_nxt = 33'(cfg.amplitude) * 33'(cos_s);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r  <= prod_nxt;
      t2_r    <= t1_r;
      idx2_r  <= idx1_r;
      last2_r <= last1_r;
    end
  end

  // round half away from zero to Q16.8, optionally to a whole number, then clamp
  always_comb begin
    neg3    = prod_r[32];
    mag_abs = neg3 ? $unsigned(-prod_r) : $unsigned(prod_r);
    mag_sh  = (mag_abs + 33'd16384) >> 15;
    mag_rnd = cfg.round_mode ? ((mag_sh + 33'd128) & ~33'd255) : mag_sh;
    if (neg3) begin
      sample_nxt = (mag_rnd > NEG_MAX) ? NEG_MAX[SB-1:0] : SB'('0 - mag_rnd);
    end else begin
      sample_nxt = (mag_rnd > POS_MAX) ? POS_MAX[SB-1:0] : mag_rnd[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sample_r <= sample_nxt;
      time_r   <= t2_r;
      index_r  <= idx2_r;
      last_r   <= last2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= !q_empty;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = sample_r;
  assign out_time   = time_r;
  assign out_index  = index_r;
  assign out_last   = last_r;

endmodule

### sv/sampled_cosine_generator_unit.sv
`timescale 1ns / 1ps
// channel   dir  handshake           payload
// in_       in   in_tvalid/tready    in_tdata[0] restart
// out_      out  out_tvalid/tready   out_tdata sample, time, index; out_tlast last sample
// cfg_      in   cfg_wr_en           cfg_addr register index, cfg_wdata value
//
// one item per clock sustained while out_tready stays high; an accepted item is
// written into the four-entry queue, then passes the table read and the
// multiply, with the output register of the back pipeline holding the result.
// rst_n is synchronous; it clears the accumulators, index, queue and valids and
// loads the register reset values. out_tready low stalls the back pipeline;
// input is still taken until the queue fills.

module sampled_cosine_generator_unit #(
  parameter int unsigned PHASE_BITS    = scg_pkg::PHASE_BITS_DEF,
  parameter int unsigned ROM_ADDR_BITS = scg_pkg::ROM_ADDR_BITS_DEF,
  parameter int unsigned INDEX_BITS    = scg_pkg::INDEX_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [scg_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [scg_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] restart, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [23:0] sample_value, [55:24] time_value,
                                  // [71:56] sample_index
  output logic        out_tlast
);

  localparam int unsigned QW = 2 + ROM_ADDR_BITS + scg_pkg::TIME_BITS
                               + scg_pkg::OIDX_BITS + 1;

  scg_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_addr)
        scg_pkg::REG_PHASE_STEP:   cfg_nxt.phase_step   = cfg_wdata;
        scg_pkg::REG_PHASE_OFFSET: cfg_nxt.phase_offset = cfg_wdata;
        scg_pkg::REG_AMPLITUDE:    cfg_nxt.amplitude    = $signed(cfg_wdata[15:0]);
        scg_pkg::REG_SAMPLE_COUNT: cfg_nxt.sample_count = cfg_wdata[15:0];
        scg_pkg::REG_TIME_START:   cfg_nxt.time_start   = cfg_wdata;
        scg_pkg::REG_TIME_STEP:    cfg_nxt.time_step    = cfg_wdata[30:0];
        scg_pkg::REG_ROUND_MODE:   cfg_nxt.round_mode   = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step   <= scg_pkg::RST_PHASE_STEP;
      cfg_r.phase_offset <= scg_pkg::RST_PHASE_OFFSET;
      cfg_r.amplitude    <= $signed(scg_pkg::RST_AMPLITUDE);
      cfg_r.sample_count <= scg_pkg::RST_SAMPLE_COUNT;
      cfg_r.time_start   <= scg_pkg::RST_TIME_START;
      cfg_r.time_step    <= scg_pkg::RST_TIME_STEP;
      cfg_r.round_mode   <= scg_pkg::RST_ROUND_MODE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  logic          q_full, q_empty, q_push, q_pop;
  logic [QW-1:0] q_wdata, q_rdata;

  scg_front #(
    .PHASE_BITS    (PHASE_BITS),
    .ROM_ADDR_BITS (ROM_ADDR_BITS),
    .INDEX_BITS    (INDEX_BITS),
    .QW            (QW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_restart (in_tdata[0]),
    .in_ready   (in_tready),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  scg_queue #(
    .WIDTH (QW),
    .DEPTH (scg_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  scg_back #(
    .ROM_ADDR_BITS (ROM_ADDR_BITS),
    .QW            (QW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (out_tdata[23:0]),
    .out_time   (out_tdata[55:24]),
    .out_index  (out_tdata[71:56]),
    .out_last   (out_tlast)
  );

endmodule

### bench/tb_sampled_cosine_generator_unit.sv
`timescale 1ns / 1ps

module tb_sampled_cosine_generator_unit;

  localparam int unsigned QUARTER = 1 << scg_pkg::ROM_ADDR_BITS_DEF;
  localparam logic [scg_pkg::CFG_ADDR_BITS-1:0] REG_UNUSED = 3'd7;
  localparam int LIMIT  = 200000;
  localparam int SETTLE = 12;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [23:0] value;
    logic [31:0] stamp;
    logic [15:0] index;
    logic        last;
  } sample_t;

  // tracks the oscillator state and the samples still owed by the block
  class sample_ledger;
    scg_pkg::cfg_t regs;
    logic [15:0]   quarter_cos [QUARTER];
    logic [31:0]   phase_acc;
    logic [31:0]   time_acc;
    logic [15:0]   index_count;
    sample_t       awaited [$];
    int            errors;

    function new();
      build_table();
      clear();
      errors = 0;
    endfunction

    // quarter-wave cosine, Q1.15, from a truncated taylor series in Q30
    function void build_table();
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] v;
      longint      sum;
      for (int k = 0; k < QUARTER; k++) begin
        x    = (scg_pkg::PI_Q30 * 64'(k)) / 64'(2 * QUARTER);
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = longint'(term);
        for (int n = 1; n <= 12; n++) begin
          term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
          if (n % 2 == 1) sum -= longint'(term);
          else sum += longint'(term);
        end
        if (sum < 0) sum = 0;
        v = (64'(sum) * 64'd32768 + (64'd1 << 29)) >> 30;
        if (v > 64'd32768) v = 64'd32768;
        quarter_cos[k] = v[15:0];
      end
    endfunction

    function void rewind();
      index_count = '0;
      phase_acc   = regs.phase_offset;
      time_acc    = regs.time_start;
    endfunction

    function void clear();
      regs.phase_step   = scg_pkg::RST_PHASE_STEP;
      regs.phase_offset = scg_pkg::RST_PHASE_OFFSET;
      regs.amplitude    = scg_pkg::RST_AMPLITUDE;
      regs.sample_count = scg_pkg::RST_SAMPLE_COUNT;
      regs.time_start   = scg_pkg::RST_TIME_START;
      regs.time_step    = scg_pkg::RST_TIME_STEP;
      regs.round_mode   = scg_pkg::RST_ROUND_MODE;
      awaited.delete();
      rewind();
    endfunction

    function void note_config(logic [scg_pkg::CFG_ADDR_BITS-1:0] idx, logic [31:0] val);
      case (idx)
        scg_pkg::REG_PHASE_STEP:   regs.phase_step   = val;
        scg_pkg::REG_PHASE_OFFSET: regs.phase_offset = val;
        scg_pkg::REG_AMPLITUDE:    regs.amplitude    = val[15:0];
        scg_pkg::REG_SAMPLE_COUNT: regs.sample_count = val[15:0];
        scg_pkg::REG_TIME_START:   regs.time_start   = val;
        scg_pkg::REG_TIME_STEP:    regs.time_step    = val[30:0];
        scg_pkg::REG_ROUND_MODE:   regs.round_mode   = val[0];
        default: ;
      endcase
    endfunction

    function void note_tick(bit restart);
      logic [16:0] last_idx;
      logic [1:0]  quad;
      logic [9:0]  addr;
      longint      cosv;
      longint      prod;
      longint      mag;
      longint      val;
      sample_t     s;
      // a zero count behaves as one
      last_idx = (regs.sample_count == 16'd0) ? 17'd0 : 17'(regs.sample_count) - 17'd1;
      if (restart) rewind();
      quad = phase_acc[31:30];
      addr = phase_acc[29:20];
      // odd quadrants read the table mirrored; a zero address there is exactly zero
      if (quad[0]) cosv = (addr == 10'd0) ? 0 : longint'(quarter_cos[QUARTER - addr]);
      else cosv = longint'(quarter_cos[addr]);
      if (quad[1] ^ quad[0]) cosv = -cosv;
      prod = longint'($signed(regs.amplitude)) * cosv;
      mag  = (prod < 0) ? -prod : prod;
      mag  = (mag + 16384) / 32768;
      if (regs.round_mode) mag = ((mag + 128) / 256) * 256;
      if (prod < 0) val = (mag > 8388608) ? -8388608 : -mag;
      else val = (mag > 8388607) ? 8388607 : mag;
      s.value = val[23:0];
      s.stamp = time_acc;
      s.index = index_count;
      s.last  = (17'(index_count) == last_idx);
      awaited.push_back(s);
      // also wraps when the count was lowered below the running index
      if (17'(index_count) >= last_idx) begin
        rewind();
      end else begin
        index_count = index_count + 16'd1;
        phase_acc   = phase_acc + regs.phase_step;
        time_acc    = time_acc + 32'(regs.time_step);
      end
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t %s expected %h got %h", $time, field, want, got);
      end
    endfunction

    function void check_sample(logic [71:0] word, logic last);
      sample_t s;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t unexpected item expected none got %h last %b", $time, word, last);
      end else begin
        s = awaited.pop_front();
        compare_field("sample_value", 32'($signed(s.value)), 32'($signed(word[23:0])));
        compare_field("time_value", s.stamp, word[55:24]);
        compare_field("sample_index", 32'(s.index), 32'(word[71:56]));
        compare_field("last_sample", 32'(s.last), 32'(last));
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                              clk;
  logic                              rst_n      = 1'b0;
  logic                              cfg_wr_en  = 1'b0;
  logic [scg_pkg::CFG_ADDR_BITS-1:0] cfg_addr   = '0;
  logic [scg_pkg::CFG_DATA_BITS-1:0] cfg_wdata  = '0;
  logic                              in_tvalid  = 1'b0;
  logic                              in_tready;
  logic [7:0]                        in_tdata   = '0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [71:0]                       out_tdata;
  logic                              out_tlast;

  int           send_idle_pct = 0;
  int           stall_pct     = 0;
  logic         holding       = 1'b0;
  int           cycles        = 0;
  event         hold_off;
  sample_ledger ledger;

  sampled_cosine_generator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    out_tready <= !holding && ($urandom_range(0, 99) >= stall_pct);
  end

  // long receiver hold-off so the queue fills and the input backs up
  always @(hold_off) begin
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) ledger.note_tick(in_tdata[0]);
    if (rst_n && out_tvalid && out_tready) ledger.check_sample(out_tdata, out_tlast);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic apply_settings(input scg_pkg::cfg_t s);
    logic [scg_pkg::CFG_DATA_BITS-1:0] vals [8];
    vals[scg_pkg::REG_PHASE_STEP]   = s.phase_step;
    vals[scg_pkg::REG_PHASE_OFFSET] = s.phase_offset;
    vals[scg_pkg::REG_AMPLITUDE]    = 32'(s.amplitude);
    vals[scg_pkg::REG_SAMPLE_COUNT] = 32'(s.sample_count);
    vals[scg_pkg::REG_TIME_START]   = s.time_start;
    vals[scg_pkg::REG_TIME_STEP]    = 32'(s.time_step);
    vals[scg_pkg::REG_ROUND_MODE]   = 32'(s.round_mode);
    vals[REG_UNUSED]                = $urandom();
    for (int i = 0; i < 8; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_addr  <= scg_pkg::CFG_ADDR_BITS'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      ledger.note_config(scg_pkg::CFG_ADDR_BITS'(i), vals[i]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // lead forces a restart on the first item
  task automatic send_ticks(input int count, input int restart_pct, input bit lead);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < send_idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= {7'd0, (lead && sent == 0) || ($urandom_range(0, 99) < restart_pct)};
        @(posedge clk);
        while (!in_tready) @(posedge clk);
        sent++;
      end
    end
    in_tvalid <= 1'b0;
  endtask

  task automatic settle();
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] pick(input logic [31:0] lo, input logic [31:0] hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      default: return $urandom();
    endcase
  endfunction

  function automatic scg_pkg::cfg_t random_settings();
    scg_pkg::cfg_t s;
    if ($urandom_range(0, 3) == 0) s.phase_step = 32'($urandom_range(0, 1 << 22));
    else s.phase_step = pick(32'd0, 32'hFFFF_FFFF);
    s.phase_offset = pick(32'd0, 32'hFFFF_FFFF);
    s.amplitude    = 16'(pick(32'h0000_8000, 32'h0000_7FFF));
    case ($urandom_range(0, 7))
      0: s.sample_count = 16'd0;
      1: s.sample_count = 16'hFFFF;
      2: s.sample_count = 16'($urandom_range(41, 400));
      default: s.sample_count = 16'($urandom_range(1, 40));
    endcase
    s.time_start = pick(32'h8000_0000, 32'h7FFF_FFFF);
    s.time_step  = 31'(pick(32'd0, 32'h7FFF_FFFF));
    s.round_mode = 1'($urandom_range(0, 1));
    return s;
  endfunction

  initial begin
    scg_pkg::cfg_t s;
    int            rpct;
    ledger = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, accumulators straight from reset
    send_ticks(2, 0, 1'b0);
    settle();

    // quarter-turn steps land on every quadrant at a table edge, time wraps
    s.phase_step   = 32'h4000_0000;
    s.phase_offset = 32'd0;
    s.amplitude    = 16'h7FFF;
    s.sample_count = 16'd5;
    s.time_start   = 32'h8000_0000;
    s.time_step    = 31'h7FFF_FFFF;
    s.round_mode   = 1'b0;
    apply_settings(s);
    send_ticks(6, 0, 1'b1);
    settle();

    // most negative amplitude, zero count acting as one
    s.phase_step   = 32'hFFFF_FFFF;
    s.phase_offset = 32'hFFFF_FFFF;
    s.amplitude    = 16'h8000;
    s.sample_count = 16'd0;
    s.time_start   = 32'h7FFF_FFFF;
    s.time_step    = 31'd0;
    s.round_mode   = 1'b1;
    apply_settings(s);
    send_ticks(3, 0, 1'b1);
    settle();

    // half amplitude on a full-scale cosine rounds away from zero both ways
    s.phase_step   = 32'h8000_0000;
    s.phase_offset = 32'd0;
    s.amplitude    = 16'h0080;
    s.sample_count = 16'hFFFF;
    s.time_start   = 32'd0;
    s.time_step    = 31'd1;
    s.round_mode   = 1'b1;
    apply_settings(s);
    send_ticks(4, 0, 1'b1);
    settle();

    // count lowered below the running index forces a wrap
    s.phase_step   = $urandom();
    s.phase_offset = $urandom();
    s.amplitude    = 16'd0;
    s.sample_count = 16'd101;
    s.time_start   = $urandom();
    s.time_step    = 31'($urandom());
    s.round_mode   = 1'b0;
    apply_settings(s);
    send_ticks(7, 0, 1'b1);
    settle();
    s.sample_count = 16'd3;
    apply_settings(s);
    send_ticks(3, 0, 1'b0);
    settle();

    for (int p = 0; p < 12; p++) begin
      apply_settings(random_settings());
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 67;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 67;
        end
        default: begin
          send_idle_pct = 26;
          stall_pct     = 26;
        end
      endcase
      case ($urandom_range(0, 2))
        0: rpct = 0;
        1: rpct = 3;
        default: rpct = 30;
      endcase
      send_ticks($urandom_range(80, 120), rpct, 1'($urandom_range(0, 1)));
      settle();
    end

    // sender keeps offering while the receiver is held off
    apply_settings(random_settings());
    send_idle_pct = 0;
    stall_pct     = 0;
    -> hold_off;
    send_ticks(80, 5, 1'b1);
    settle();

    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
